// File: sv/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int PHASE_BITS  = 16;
   localparam int MAX_OUTPUTS = 32;
   localparam int COUNT_W     = $clog2(MAX_OUTPUTS + 1);
   localparam int INDEX_W     = 5;
   localparam int AXES        = 3;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int PROD_W      = DIFF_W + PHASE_BITS + 1;
   localparam int NUM_W       = PROD_W + 1;
   localparam int QUOT_W      = NUM_W - PHASE_BITS;

   localparam logic [PHASE_BITS-1:0] INC_RESET = PHASE_BITS'(32768);

   localparam logic KIND_ANCHOR = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic load_anchor;
      logic load_sample;
      logic do_mul;
      logic do_fin;
   } cmd_type;

   typedef struct packed {
      logic limit;
      logic last;
   } status_type;

endpackage

// File: sv/lir_ctrl.sv
`timescale 1ns / 1ps

module lir_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lir_pkg::status_type  status,
   output lir_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIN,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load_anchor = accept && (req_kind == lir_pkg::KIND_ANCHOR);
      cmd.load_sample = accept && (req_kind == lir_pkg::KIND_SAMPLE) && !status.limit;
      cmd.do_mul      = (state_ff == ST_MUL);
      cmd.do_fin      = (state_ff == ST_FIN);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_sample) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in     = ST_OUT;
            rsp_valid_in = 1'b1;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               // phase wrapped or limit hit: this request is done
               state_in     = status.last ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/lir_datapath.sv
`timescale 1ns / 1ps

module lir_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lir_pkg::cmd_type                      cmd,
   output lir_pkg::status_type                   status,
   input  logic signed [lir_pkg::SAMPLE_W-1:0]   req_x,
   input  logic signed [lir_pkg::SAMPLE_W-1:0]   req_y,
   input  logic signed [lir_pkg::SAMPLE_W-1:0]   req_z,
   input  logic        [lir_pkg::PHASE_BITS-1:0] req_start_phase,
   input  logic                                  csr_write,
   input  logic        [lir_pkg::PHASE_BITS-1:0] csr_phase_increment,
   output logic signed [lir_pkg::SAMPLE_W-1:0]   rsp_out_x,
   output logic signed [lir_pkg::SAMPLE_W-1:0]   rsp_out_y,
   output logic signed [lir_pkg::SAMPLE_W-1:0]   rsp_out_z,
   output logic        [lir_pkg::INDEX_W-1:0]    rsp_output_index,
   output logic                                  rsp_last_of_run
);

   logic signed [lir_pkg::SAMPLE_W-1:0]   a_ff    [lir_pkg::AXES];
   logic signed [lir_pkg::SAMPLE_W-1:0]   b_ff    [lir_pkg::AXES];
   logic signed [lir_pkg::PROD_W-1:0]     prod_ff [lir_pkg::AXES];
   logic signed [lir_pkg::PROD_W-1:0]     prod_in [lir_pkg::AXES];
   logic signed [lir_pkg::SAMPLE_W-1:0]   out_ff  [lir_pkg::AXES];
   logic signed [lir_pkg::SAMPLE_W-1:0]   out_in  [lir_pkg::AXES];
   logic signed [lir_pkg::SAMPLE_W-1:0]   req_s   [lir_pkg::AXES];
   logic        [lir_pkg::PHASE_BITS-1:0] phase_ff;
   logic        [lir_pkg::PHASE_BITS-1:0] inc_ff;
   logic        [lir_pkg::COUNT_W-1:0]    count_ff;
   logic        [lir_pkg::COUNT_W-1:0]    count_in;
   logic        [lir_pkg::INDEX_W-1:0]    index_ff;
   logic                                  last_ff;
   logic        [lir_pkg::PHASE_BITS:0]   phase_sum;
   logic                                  wrap;

   assign req_s[0] = req_x;
   assign req_s[1] = req_y;
   assign req_s[2] = req_z;

   assign phase_sum = {1'b0, phase_ff} + {1'b0, inc_ff};
   assign wrap      = phase_sum[lir_pkg::PHASE_BITS];
   assign count_in  = count_ff + lir_pkg::COUNT_W'(1);

   assign status.limit = (count_ff == lir_pkg::COUNT_W'(lir_pkg::MAX_OUTPUTS));
   assign status.last  = last_ff;

   // per axis: phase*(b-a), then a*one + product truncated toward zero
   always_comb begin
      logic signed [lir_pkg::DIFF_W-1:0]       diff;
      logic signed [lir_pkg::PHASE_BITS:0]     ph_s;
      logic signed [lir_pkg::NUM_W-1:0]        num;
      logic signed [lir_pkg::QUOT_W-1:0]       quot;
      diff = '0;
      ph_s = '0;
      num  = '0;
      quot = '0;
      for (int i = 0; i < lir_pkg::AXES; i++) begin
         diff = {b_ff[i][lir_pkg::SAMPLE_W-1], b_ff[i]}
              - {a_ff[i][lir_pkg::SAMPLE_W-1], a_ff[i]};
         ph_s = {1'b0, phase_ff};
         prod_in[i] = lir_pkg::PROD_W'(diff) * lir_pkg::PROD_W'(ph_s);
         num = {{(lir_pkg::NUM_W - lir_pkg::SAMPLE_W - lir_pkg::PHASE_BITS)
                 {a_ff[i][lir_pkg::SAMPLE_W-1]}},
                a_ff[i], {lir_pkg::PHASE_BITS{1'b0}}}
             + {prod_ff[i][lir_pkg::PROD_W-1], prod_ff[i]};
         quot = num[lir_pkg::NUM_W-1:lir_pkg::PHASE_BITS];
         if (num[lir_pkg::NUM_W-1] && (|num[lir_pkg::PHASE_BITS-1:0])) begin
            quot = quot + lir_pkg::QUOT_W'(1);
         end
         out_in[i] = quot[lir_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff   <= lir_pkg::INC_RESET;
         phase_ff <= '0;
         count_ff <= '0;
         last_ff  <= 1'b0;
         for (int i = 0; i < lir_pkg::AXES; i++) begin
            a_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            inc_ff <= csr_phase_increment;
         end
         if (cmd.load_anchor) begin
            phase_ff <= req_start_phase;
            count_ff <= '0;
            for (int i = 0; i < lir_pkg::AXES; i++) begin
               a_ff[i] <= req_s[i];
            end
         end
         if (cmd.do_fin) begin
            phase_ff <= phase_sum[lir_pkg::PHASE_BITS-1:0];
            count_ff <= count_in;
            last_ff  <= wrap || (count_in == lir_pkg::COUNT_W'(lir_pkg::MAX_OUTPUTS));
            if (wrap) begin
               for (int i = 0; i < lir_pkg::AXES; i++) begin
                  a_ff[i] <= b_ff[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         for (int i = 0; i < lir_pkg::AXES; i++) begin
            b_ff[i] <= req_s[i];
         end
      end
      if (cmd.do_mul) begin
         for (int i = 0; i < lir_pkg::AXES; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (cmd.do_fin) begin
         index_ff <= count_ff[lir_pkg::INDEX_W-1:0];
         for (int i = 0; i < lir_pkg::AXES; i++) begin
            out_ff[i] <= out_in[i];
         end
      end
   end

   assign rsp_out_x        = out_ff[0];
   assign rsp_out_y        = out_ff[1];
   assign rsp_out_z        = out_ff[2];
   assign rsp_output_index = index_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

// File: sv/linear_interp_resampler.sv
`timescale 1ns / 1ps
// anchor request: taken while idle, leaves the block idle, gives no result
// sample request (dropped once the output limit is reached): each result passes the multiply stage,
// then the round stage into the output register; a further result starts once the previous is taken
// a sample request occupies the block until its last result is taken, output stalls included
// reset: synchronous, clears phase, count and previous sample, increment back to 32768
module linear_interp_resampler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic signed [lir_pkg::SAMPLE_W-1:0]   req_x,
   input  logic signed [lir_pkg::SAMPLE_W-1:0]   req_y,
   input  logic signed [lir_pkg::SAMPLE_W-1:0]   req_z,
   input  logic        [lir_pkg::PHASE_BITS-1:0] req_start_phase,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lir_pkg::SAMPLE_W-1:0]   rsp_out_x,
   output logic signed [lir_pkg::SAMPLE_W-1:0]   rsp_out_y,
   output logic signed [lir_pkg::SAMPLE_W-1:0]   rsp_out_z,
   output logic        [lir_pkg::INDEX_W-1:0]    rsp_output_index,
   output logic                                  rsp_last_of_run,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [lir_pkg::PHASE_BITS-1:0] csr_phase_increment
);

   lir_pkg::cmd_type    cmd;
   lir_pkg::status_type status;

   assign csr_ready = 1'b1;

   lir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lir_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_x               (req_x),
      .req_y               (req_y),
      .req_z               (req_z),
      .req_start_phase     (req_start_phase),
      .csr_write           (csr_valid && csr_ready),
      .csr_phase_increment (csr_phase_increment),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_z           (rsp_out_z),
      .rsp_output_index    (rsp_output_index),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule
